// File: design/dpc_pkg.sv
package dpc_pkg;

    localparam int FRAC_BITS = 16;
    localparam int EXP_FRAC  = 24;

    localparam int RAW_W   = 32;
    localparam int CNT_W   = 8;
    localparam int COEF_W  = 32;
    localparam int RESP_W  = 18;
    localparam int COAD_W  = 16;
    localparam int OUT_W   = 48;

    // derived datapath widths
    localparam int D_W     = COAD_W + CNT_W;            // coadditions * pixel_count
    localparam int S0_W    = RAW_W + FRAC_BITS;         // binned signal quotient
    localparam int S_W     = S0_W + 2;                  // after dark offset, signed
    localparam int MAG_W   = S0_W + 1;                  // |s|
    localparam int DC_W    = 2 * COEF_W - EXP_FRAC;     // dark current term, signed
    localparam int S2_W    = S_W + 1;                   // after dark current, signed
    localparam int MAG2_W  = S2_W;
    localparam int VAR_W   = COEF_W + MAG_W + 1;        // g*|s| + n2, before binning
    localparam int ROOT_W  = VAR_W / 2;
    localparam int PR_W    = MAG2_W + FRAC_BITS;        // PRNU dividend width

    localparam logic [RESP_W-1:0] ONE_RESP  = RESP_W'(1) << FRAC_BITS;
    localparam logic [ROOT_W-1:0] ONE_NOISE = ROOT_W'(1) << FRAC_BITS;

    localparam logic [PR_W-1:0] SIG_POS_MAX = PR_W'((64'd1 << (OUT_W - 1)) - 64'd1);
    localparam logic [PR_W-1:0] SIG_NEG_MAG = PR_W'(64'd1 << (OUT_W - 1));
    localparam logic [PR_W-1:0] NOISE_MAX   = PR_W'((64'd1 << OUT_W) - 64'd1);

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SAT  = 2'd1,
        ST_DIV0 = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        CFG_COAD       = 3'd0,
        CFG_EXP_TIME   = 3'd1,
        CFG_OFFSET_EN  = 3'd2,
        CFG_NOISE_EN   = 3'd3,
        CFG_CURRENT_EN = 3'd4,
        CFG_PRNU_EN    = 3'd5
    } t_cfg_idx;

endpackage

// File: design/detector_pixel_calibration_unit.sv
// Detector pixel calibration: dark offset, noise estimate, dark current, PRNU.
// Input stream (s_axis_*) carries one pixel bin per item with its coefficients;
// output stream (m_axis_*) returns calibrated signal and noise, status in tuser.
// Config channel (i_cfg_*) writes the six registers by index; it is always
// ready; the user must write it only while no items are in flight, as the
// block does not enforce this. Throughput: one item per clock unless the
// output stalls. Items flow through bit-serial pipelines: 48-stage bin divider,
// 82-stage noise divider, 41-stage square root, 67-stage PRNU divider, plus
// capture, offset, magnitude, two multiply, select and output stages.
// Reset clears all valid bits and loads coadditions 1, exposure 0, enables 1.
// When m_axis_tready is low with an item held at the output, the whole pipeline
// freezes and s_axis_tready drops; nothing is dropped or repeated, and an empty
// output register lets the pipeline advance regardless of tready.
module detector_pixel_calibration_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] raw_sum, [39:32] pixel_count, [71:40] offset_coeff,
    // [103:72] current_coeff, [135:104] noise_gain, [167:136] read_noise_sq,
    // [185:168] response_coeff, [191:186] zero
    input  logic [191:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [47:0] signal_out, [95:48] noise_out
    output logic [95:0]  m_axis_tdata,
    // [1:0] status
    output logic [1:0]   m_axis_tuser,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [2:0]   i_cfg_index,
    input  logic [31:0]  i_cfg_data
);

    localparam int F   = dpc_pkg::FRAC_BITS;
    localparam int CW  = dpc_pkg::COEF_W;
    localparam int DW  = dpc_pkg::D_W;
    localparam int RW  = dpc_pkg::RESP_W;
    localparam int P1W = 1 + DW + 4 * CW + RW;       // bin divider sideband
    localparam int P2W = dpc_pkg::S2_W + 1 + RW;      // noise divider / sqrt sideband

    // ---------------- configuration ----------------
    logic [dpc_pkg::COAD_W-1:0] r_coad;
    logic [31:0]                r_exp;
    logic                       r_offset_en;
    logic                       r_noise_en;
    logic                       r_current_en;
    logic                       r_prnu_en;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coad       <= dpc_pkg::COAD_W'(1);
            r_exp        <= '0;
            r_offset_en  <= 1'b1;
            r_noise_en   <= 1'b1;
            r_current_en <= 1'b1;
            r_prnu_en    <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                dpc_pkg::CFG_COAD:       r_coad       <= i_cfg_data[dpc_pkg::COAD_W-1:0];
                dpc_pkg::CFG_EXP_TIME:   r_exp        <= i_cfg_data;
                dpc_pkg::CFG_OFFSET_EN:  r_offset_en  <= i_cfg_data[0];
                dpc_pkg::CFG_NOISE_EN:   r_noise_en   <= i_cfg_data[0];
                dpc_pkg::CFG_CURRENT_EN: r_current_en <= i_cfg_data[0];
                dpc_pkg::CFG_PRNU_EN:    r_prnu_en    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    logic adv;
    logic r_m_valid;

    assign adv           = !r_m_valid || m_axis_tready;
    assign s_axis_tready = adv;

    // ---------------- stage A: capture, bin divisor ----------------
    logic [dpc_pkg::CNT_W-1:0] in_cnt;
    logic [RW-1:0]             in_resp;

    assign in_cnt  = s_axis_tdata[39:32];
    assign in_resp = s_axis_tdata[185:168];

    logic          r_a_vld;
    logic [31:0]   r_a_raw;
    logic [DW-1:0] r_a_d;
    logic          r_a_dz;
    logic [CW-1:0] r_a_off, r_a_cur, r_a_gain, r_a_n2;
    logic [RW-1:0] r_a_resp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (adv) begin
            r_a_vld <= s_axis_tvalid;
        end
        if (adv) begin
            r_a_raw  <= s_axis_tdata[31:0];
            r_a_d    <= r_coad * in_cnt;
            r_a_dz   <= (r_coad == '0) || (in_cnt == '0) || (r_prnu_en && in_resp == '0);
            r_a_off  <= s_axis_tdata[71:40];
            r_a_cur  <= s_axis_tdata[103:72];
            r_a_gain <= s_axis_tdata[135:104];
            r_a_n2   <= s_axis_tdata[167:136];
            r_a_resp <= in_resp;
        end
    end

    // ---------------- bin division ----------------
    logic                     d1_vld;
    logic [dpc_pkg::S0_W-1:0] d1_quo;
    logic [P1W-1:0]           d1_pay;

    dpc_div_pipe #(.NW(dpc_pkg::S0_W), .DW(DW), .PW(P1W)) u_bin_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_a_vld),
        .i_num   ({r_a_raw, {F{1'b0}}}),
        .i_den   (r_a_d),
        .i_pay   ({r_a_dz, r_a_d, r_a_off, r_a_cur, r_a_gain, r_a_n2, r_a_resp}),
        .o_valid (d1_vld),
        .o_quo   (d1_quo),
        .o_pay   (d1_pay)
    );

    logic          d1_dz;
    logic [DW-1:0] d1_d;
    logic [CW-1:0] d1_off, d1_cur, d1_gain, d1_n2;
    logic [RW-1:0] d1_resp;

    assign {d1_dz, d1_d, d1_off, d1_cur, d1_gain, d1_n2, d1_resp} = d1_pay;

    // ---------------- stage B: dark offset, dark current product ----------------
    logic signed [dpc_pkg::S_W-1:0] off_ext;
    logic signed [2*CW:0]           dc_prod;

    assign off_ext = r_offset_en ? dpc_pkg::S_W'($signed(d1_off)) : '0;
    assign dc_prod = $signed(d1_cur) * $signed({1'b0, r_exp});

    logic                             r_b_vld;
    logic signed [dpc_pkg::S_W-1:0]   r_b_s;
    logic signed [dpc_pkg::DC_W-1:0]  r_b_dc;
    logic                             r_b_dz;
    logic [DW-1:0]                    r_b_d;
    logic [CW-1:0]                    r_b_gain, r_b_n2;
    logic [RW-1:0]                    r_b_resp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (adv) begin
            r_b_vld <= d1_vld;
        end
        if (adv) begin
            r_b_s    <= $signed({2'b00, d1_quo}) - off_ext;
            // floor shift: bit 2*CW-1 is the sign, product never reaches 2^63
            r_b_dc   <= dc_prod[2*CW-1:dpc_pkg::EXP_FRAC];
            r_b_dz   <= d1_dz;
            r_b_d    <= d1_d;
            r_b_gain <= d1_gain;
            r_b_n2   <= d1_n2;
            r_b_resp <= d1_resp;
        end
    end

    // ---------------- stage C: |s|, subtract dark current ----------------
    logic [dpc_pkg::S_W-1:0]         s_abs;
    logic signed [dpc_pkg::S2_W-1:0] dc_ext;

    assign s_abs  = r_b_s[dpc_pkg::S_W-1] ? dpc_pkg::S_W'(-r_b_s) : r_b_s;
    assign dc_ext = r_current_en ? dpc_pkg::S2_W'(r_b_dc) : '0;

    logic                             r_c_vld;
    logic [dpc_pkg::MAG_W-1:0]        r_c_mag;
    logic signed [dpc_pkg::S2_W-1:0]  r_c_s2;
    logic                             r_c_dz;
    logic [DW-1:0]                    r_c_d;
    logic [CW-1:0]                    r_c_gain, r_c_n2;
    logic [RW-1:0]                    r_c_resp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (adv) begin
            r_c_vld <= r_b_vld;
        end
        if (adv) begin
            r_c_mag  <= s_abs[dpc_pkg::MAG_W-1:0];
            r_c_s2   <= dpc_pkg::S2_W'(r_b_s) - dc_ext;
            r_c_dz   <= r_b_dz;
            r_c_d    <= r_b_d;
            r_c_gain <= r_b_gain;
            r_c_n2   <= r_b_n2;
            r_c_resp <= r_b_resp;
        end
    end

    // ---------------- stage D: partial products g*|s| ----------------
    localparam int PH_W = CW + dpc_pkg::MAG_W - 32;

    logic                             r_d_vld;
    logic [2*CW-1:0]                  r_d_pl;
    logic [PH_W-1:0]                  r_d_ph;
    logic [CW-1:0]                    r_d_n2;
    logic signed [dpc_pkg::S2_W-1:0]  r_d_s2;
    logic                             r_d_dz;
    logic [DW-1:0]                    r_d_d;
    logic [RW-1:0]                    r_d_resp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (adv) begin
            r_d_vld <= r_c_vld;
        end
        if (adv) begin
            r_d_pl   <= r_c_gain * r_c_mag[31:0];
            r_d_ph   <= r_c_gain * r_c_mag[dpc_pkg::MAG_W-1:32];
            r_d_n2   <= r_c_n2;
            r_d_s2   <= r_c_s2;
            r_d_dz   <= r_c_dz;
            r_d_d    <= r_c_d;
            r_d_resp <= r_c_resp;
        end
    end

    // ---------------- stage E: g*|s| + n2 ----------------
    localparam int VW = dpc_pkg::VAR_W;

    logic                             r_e_vld;
    logic [VW-1:0]                    r_e_sum;
    logic signed [dpc_pkg::S2_W-1:0]  r_e_s2;
    logic                             r_e_dz;
    logic [DW-1:0]                    r_e_d;
    logic [RW-1:0]                    r_e_resp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (adv) begin
            r_e_vld <= r_d_vld;
        end
        if (adv) begin
            r_e_sum  <= VW'(r_d_pl) + VW'({r_d_ph, 32'b0}) + VW'({r_d_n2, {F{1'b0}}});
            r_e_s2   <= r_d_s2;
            r_e_dz   <= r_d_dz;
            r_e_d    <= r_d_d;
            r_e_resp <= r_d_resp;
        end
    end

    // ---------------- noise division and square root ----------------
    logic           d2_vld;
    logic [VW-1:0]  d2_quo;
    logic [P2W-1:0] d2_pay;

    dpc_div_pipe #(.NW(VW), .DW(DW), .PW(P2W)) u_var_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_e_vld),
        .i_num   (r_e_sum),
        .i_den   (r_e_d),
        .i_pay   ({r_e_s2, r_e_dz, r_e_resp}),
        .o_valid (d2_vld),
        .o_quo   (d2_quo),
        .o_pay   (d2_pay)
    );

    logic                       sq_vld;
    logic [dpc_pkg::ROOT_W-1:0] sq_root;
    logic [P2W-1:0]             sq_pay;

    dpc_sqrt_pipe #(.VW(VW), .PW(P2W)) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (d2_vld),
        .i_val   (d2_quo),
        .i_pay   (d2_pay),
        .o_valid (sq_vld),
        .o_root  (sq_root),
        .o_pay   (sq_pay)
    );

    logic signed [dpc_pkg::S2_W-1:0] sq_s2;
    logic                            sq_dz;
    logic [RW-1:0]                   sq_resp;

    assign {sq_s2, sq_dz, sq_resp} = sq_pay;

    // ---------------- stage F: select noise, |s2|, PRNU divisor ----------------
    // with PRNU off the divisor is 1.0, which passes both values unchanged
    logic                         r_f_vld;
    logic [dpc_pkg::MAG2_W-1:0]   r_f_mag;
    logic                         r_f_neg;
    logic [dpc_pkg::ROOT_W-1:0]   r_f_noise;
    logic                         r_f_dz;
    logic [RW-1:0]                r_f_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (adv) begin
            r_f_vld <= sq_vld;
        end
        if (adv) begin
            r_f_mag   <= sq_s2[dpc_pkg::S2_W-1] ? dpc_pkg::MAG2_W'(-sq_s2) : sq_s2;
            r_f_neg   <= sq_s2[dpc_pkg::S2_W-1];
            r_f_noise <= r_noise_en ? sq_root : dpc_pkg::ONE_NOISE;
            r_f_dz    <= sq_dz;
            r_f_den   <= r_prnu_en ? sq_resp : dpc_pkg::ONE_RESP;
        end
    end

    // ---------------- PRNU division ----------------
    localparam int PR = dpc_pkg::PR_W;

    logic          p1_vld, p2_vld;
    logic [PR-1:0] p1_quo, p2_quo;
    logic          p1_neg, p2_dz;

    dpc_div_pipe #(.NW(PR), .DW(RW), .PW(1)) u_sig_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_f_vld),
        .i_num   ({r_f_mag, {F{1'b0}}}),
        .i_den   (r_f_den),
        .i_pay   (r_f_neg),
        .o_valid (p1_vld),
        .o_quo   (p1_quo),
        .o_pay   (p1_neg)
    );

    dpc_div_pipe #(.NW(PR), .DW(RW), .PW(1)) u_noise_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (adv),
        .i_valid (r_f_vld),
        .i_num   (PR'({r_f_noise, {F{1'b0}}})),
        .i_den   (r_f_den),
        .i_pay   (r_f_dz),
        .o_valid (p2_vld),
        .o_quo   (p2_quo),
        .o_pay   (p2_dz)
    );

    // ---------------- stage G: saturate, output register ----------------
    logic                       sig_sat, noise_sat;
    logic [dpc_pkg::OUT_W-1:0]  sig_mag, sig_val, noise_val;
    dpc_pkg::t_status           status_val;

    always_comb begin
        sig_sat   = p1_neg ? (p1_quo > dpc_pkg::SIG_NEG_MAG) : (p1_quo > dpc_pkg::SIG_POS_MAX);
        noise_sat = p2_quo > dpc_pkg::NOISE_MAX;
        if (sig_sat) begin
            sig_mag = p1_neg ? dpc_pkg::SIG_NEG_MAG[dpc_pkg::OUT_W-1:0]
                             : dpc_pkg::SIG_POS_MAX[dpc_pkg::OUT_W-1:0];
        end else begin
            sig_mag = p1_quo[dpc_pkg::OUT_W-1:0];
        end
        noise_val = noise_sat ? dpc_pkg::NOISE_MAX[dpc_pkg::OUT_W-1:0]
                              : p2_quo[dpc_pkg::OUT_W-1:0];
        sig_val   = p1_neg ? -sig_mag : sig_mag;
        if (p2_dz) begin
            status_val = dpc_pkg::ST_DIV0;
            sig_val    = '0;
            noise_val  = '0;
        end else if (sig_sat || noise_sat) begin
            status_val = dpc_pkg::ST_SAT;
        end else begin
            status_val = dpc_pkg::ST_OK;
        end
    end

    logic [dpc_pkg::OUT_W-1:0] r_m_sig, r_m_noise;
    dpc_pkg::t_status          r_m_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (adv) begin
            r_m_valid <= p1_vld && p2_vld;
        end
        if (adv) begin
            r_m_sig    <= sig_val;
            r_m_noise  <= noise_val;
            r_m_status <= status_val;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {r_m_noise, r_m_sig};
    assign m_axis_tuser  = r_m_status;

    // ---------------- assertions ----------------
    a_prnu_lanes_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        p1_vld == p2_vld)
        else $error("PRNU divider lanes out of step");

    a_div0_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == dpc_pkg::ST_DIV0) |-> m_axis_tdata == '0)
        else $error("divide-by-zero item carries nonzero data");

    a_unit_noise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !r_noise_en && !r_prnu_en && m_axis_tuser != dpc_pkg::ST_DIV0)
        |-> m_axis_tdata[95:48] == 48'(dpc_pkg::ONE_NOISE))
        else $error("disabled noise is not one");

endmodule

// File: design/dpc_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage, NW stages.
module dpc_div_pipe #(
    parameter int NW = 48,
    parameter int DW = 24,
    parameter int PW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [PW-1:0] i_pay,
    output logic          o_valid,
    output logic [NW-1:0] o_quo,
    output logic [PW-1:0] o_pay
);

    logic          r_vld [NW];
    logic [NW-1:0] r_nq  [NW];   // remaining dividend bits above, quotient bits below
    logic [DW-1:0] r_rem [NW];
    logic [DW-1:0] r_den [NW];
    logic [PW-1:0] r_pay [NW];

    for (genvar k = 0; k < NW; k++) begin : g_st
        logic          v_in;
        logic [NW-1:0] nq_in;
        logic [DW-1:0] rem_in;
        logic [DW-1:0] den_in;
        logic [PW-1:0] pay_in;
        logic [DW:0]   t;
        logic          ge;

        if (k == 0) begin : g_first
            assign v_in   = i_valid;
            assign nq_in  = i_num;
            assign rem_in = '0;
            assign den_in = i_den;
            assign pay_in = i_pay;
        end else begin : g_next
            assign v_in   = r_vld[k-1];
            assign nq_in  = r_nq[k-1];
            assign rem_in = r_rem[k-1];
            assign den_in = r_den[k-1];
            assign pay_in = r_pay[k-1];
        end

        assign t  = {rem_in, nq_in[NW-1]};
        assign ge = t >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v_in;
            end
            if (i_en) begin
                r_nq[k]  <= {nq_in[NW-2:0], ge};
                r_rem[k] <= ge ? DW'(t - {1'b0, den_in}) : t[DW-1:0];
                r_den[k] <= den_in;
                r_pay[k] <= pay_in;
            end
        end
    end

    assign o_valid = r_vld[NW-1];
    assign o_quo   = r_nq[NW-1];
    assign o_pay   = r_pay[NW-1];

endmodule

// File: design/dpc_sqrt_pipe.sv
// Pipelined integer square root (floor), two radicand bits per stage.
module dpc_sqrt_pipe #(
    parameter int VW = 82,
    parameter int PW = 1
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  logic [VW-1:0]   i_val,
    input  logic [PW-1:0]   i_pay,
    output logic            o_valid,
    output logic [VW/2-1:0] o_root,
    output logic [PW-1:0]   o_pay
);

    localparam int HW = VW / 2;

    logic          r_vld  [HW];
    logic [VW-1:0] r_v    [HW];
    logic [HW+1:0] r_rem  [HW];
    logic [HW-1:0] r_root [HW];
    logic [PW-1:0] r_pay  [HW];

    for (genvar k = 0; k < HW; k++) begin : g_st
        logic          v_in;
        logic [VW-1:0] val_in;
        logic [HW+1:0] rem_in;
        logic [HW-1:0] root_in;
        logic [PW-1:0] pay_in;
        logic [HW+3:0] t;
        logic [HW+3:0] trial;
        logic          ge;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign val_in  = i_val;
            assign rem_in  = '0;
            assign root_in = '0;
            assign pay_in  = i_pay;
        end else begin : g_next
            assign v_in    = r_vld[k-1];
            assign val_in  = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign root_in = r_root[k-1];
            assign pay_in  = r_pay[k-1];
        end

        assign t     = {rem_in, val_in[VW-1:VW-2]};
        assign trial = {2'b00, root_in, 2'b01};
        assign ge    = t >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= v_in;
            end
            if (i_en) begin
                r_v[k]    <= {val_in[VW-3:0], 2'b00};
                r_rem[k]  <= ge ? (HW+2)'(t - trial) : t[HW+1:0];
                r_root[k] <= {root_in[HW-2:0], ge};
                r_pay[k]  <= pay_in;
            end
        end
    end

    assign o_valid = r_vld[HW-1];
    assign o_root  = r_root[HW-1];
    assign o_pay   = r_pay[HW-1];

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import dpc_pkg::*;

    localparam int LATENCY   = 245;
    localparam int WDOG_MAX  = 20000;
    localparam int N_RANDOM  = 1920;

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] noise;
        logic [47:0] signal;
    } t_cal;

    typedef struct {
        logic [31:0] raw;
        logic [7:0]  cnt;
        logic [31:0] offs;
        logic [31:0] curr;
        logic [31:0] gain;
        logic [31:0] n2;
        logic [17:0] resp;
    } t_pixel;

    typedef struct {
        t_pixel  px;
        logic    known;   // expected value typed in
        t_cal    cal;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [191:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [95:0]  m_axis_tdata;
    logic [1:0]   m_axis_tuser;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [2:0]   i_cfg_index;
    logic [31:0]  i_cfg_data;

    detector_pixel_calibration_unit dut (.*);

    // predictor copy of the registers
    logic [15:0] cal_coad;
    logic [31:0] cal_exp;
    logic        cal_en_off, cal_en_noise, cal_en_cur, cal_en_prnu;

    t_cal   expected_cal_q[$];
    int     n_errors;
    int     n_checked;
    int     n_sat, n_div0;
    int     idle_pct_in, idle_pct_out;
    int     wdog;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic logic [63:0] root_floor(logic [127:0] v);
        logic [63:0]  r;
        logic [63:0]  t;
        r = '0;
        for (int b = 63; b >= 0; b--) begin
            t = r | (64'd1 << b);
            if ({64'd0, t} * {64'd0, t} <= v) r = t;
        end
        return r;
    endfunction

    function automatic t_cal calibrate(t_pixel p);
        t_cal          c;
        logic [63:0]   d;
        logic signed [79:0]  sig;
        logic signed [79:0]  prod;
        logic signed [79:0]  dark;
        logic [127:0]  var_q;
        logic [127:0]  mag;
        logic [127:0]  noise;
        logic          neg;
        c.status = ST_OK;
        d = 64'(cal_coad) * 64'(p.cnt);
        if (d == 0 || (cal_en_prnu && p.resp == 0)) begin
            c.signal = '0;
            c.noise  = '0;
            c.status = ST_DIV0;
            return c;
        end
        sig = 80'(({32'd0, p.raw} << FRAC_BITS) / d);
        if (cal_en_off) sig = sig - 80'(signed'(p.offs));
        if (cal_en_noise) begin
            mag   = sig < 0 ? 128'(-sig) : 128'(sig);
            var_q = (128'(p.gain) * mag + (128'(p.n2) << FRAC_BITS)) / 128'(d);
            noise = 128'(root_floor(var_q));
        end else begin
            noise = 128'(1) << FRAC_BITS;
        end
        if (cal_en_cur) begin
            prod = 80'(signed'(p.curr)) * signed'({48'd0, cal_exp});
            dark = prod >>> EXP_FRAC;   // arithmetic shift floors
            sig  = sig - dark;
        end
        neg = sig < 0;
        mag = neg ? 128'(-sig) : 128'(sig);
        if (cal_en_prnu) begin
            mag   = (mag << FRAC_BITS) / 128'(p.resp);
            noise = (noise << FRAC_BITS) / 128'(p.resp);
            if (mag > 128'(64'hFFFF_FFFF_FFFF_FFFF)) mag = 128'(64'hFFFF_FFFF_FFFF_FFFF);
            if (noise > 128'(64'hFFFF_FFFF_FFFF_FFFF)) noise = 128'(64'hFFFF_FFFF_FFFF_FFFF);
        end
        if (neg && mag > 128'(48'h8000_0000_0000)) begin
            mag = 128'(48'h8000_0000_0000);
            c.status = ST_SAT;
        end else if (!neg && mag > 128'(48'h7FFF_FFFF_FFFF)) begin
            mag = 128'(48'h7FFF_FFFF_FFFF);
            c.status = ST_SAT;
        end
        if (noise > 128'(48'hFFFF_FFFF_FFFF)) begin
            noise = 128'(48'hFFFF_FFFF_FFFF);
            c.status = ST_SAT;
        end
        c.signal = neg ? 48'(-mag) : 48'(mag);
        c.noise  = 48'(noise);
        return c;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [31:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_COAD:       cal_coad     = val[15:0];
            CFG_EXP_TIME:   cal_exp      = val;
            CFG_OFFSET_EN:  cal_en_off   = val[0];
            CFG_NOISE_EN:   cal_en_noise = val[0];
            CFG_CURRENT_EN: cal_en_cur   = val[0];
            CFG_PRNU_EN:    cal_en_prnu  = val[0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [15:0] coad, logic [31:0] expt, logic [3:0] en);
        write_reg(CFG_COAD, {$urandom} << 16 | coad);
        write_reg(CFG_EXP_TIME, expt);
        write_reg(CFG_OFFSET_EN, {$urandom} << 1 | en[0]);
        write_reg(CFG_NOISE_EN, {$urandom} << 1 | en[1]);
        write_reg(CFG_CURRENT_EN, {$urandom} << 1 | en[2]);
        write_reg(CFG_PRNU_EN, {$urandom} << 1 | en[3]);
    endtask

    // drain, then let the pipeline settle before touching registers
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_cal_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
    endtask

    // valid stays high after an accept so items can follow back to back
    task automatic send_pixel(t_pixel p, logic known, t_cal cal);
        if ($urandom_range(99) < idle_pct_in) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < idle_pct_in) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'd0, p.resp, p.n2, p.gain, p.curr, p.offs, p.cnt, p.raw};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_cal_q.push_back(known ? cal : calibrate(p));
    endtask

    function automatic t_pixel random_pixel();
        t_pixel p;
        int     shape;
        shape  = $urandom_range(9);
        p.raw  = shape < 2 ? $urandom_range(4096) : $urandom;
        p.cnt  = shape == 3 ? 8'd0 : (shape < 6 ? 8'($urandom_range(1, 8)) : 8'($urandom));
        p.offs = shape < 5 ? 32'($signed($urandom_range(200000)) - 100000) : $urandom;
        p.curr = shape < 5 ? 32'($signed($urandom_range(200000)) - 100000) : $urandom;
        p.gain = $urandom;
        p.n2   = $urandom;
        p.resp = shape == 4 ? 18'd0 : (shape < 7 ? 18'($urandom_range(32768, 98304))
                                                 : 18'($urandom));
        return p;
    endfunction

    // monitor and checker
    always @(posedge i_clk) begin
        t_cal got;
        t_cal exp_c;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser, m_axis_tdata};
                if (expected_cal_q.size() == 0) begin
                    $display("%0t: result with nothing expected: %h", $realtime, got);
                    n_errors++;
                end else begin
                    exp_c = expected_cal_q.pop_front();
                    n_checked++;
                    if (exp_c.status == ST_SAT) n_sat++;
                    if (exp_c.status == ST_DIV0) n_div0++;
                    if (got.signal !== exp_c.signal) begin
                        $display("%0t: signal expected %h actual %h", $realtime,
                                 exp_c.signal, got.signal);
                        n_errors++;
                    end
                    if (got.noise !== exp_c.noise) begin
                        $display("%0t: noise expected %h actual %h", $realtime,
                                 exp_c.noise, got.noise);
                        n_errors++;
                    end
                    if (got.status !== exp_c.status) begin
                        $display("%0t: status expected %0d actual %0d", $realtime,
                                 exp_c.status, got.status);
                        n_errors++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= idle_pct_out);
        end
    end

    // watchdog: cycles with no item accepted while something is pending
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (i_cfg_valid && o_cfg_ready)
            || (expected_cal_q.size() == 0 && !s_axis_tvalid && !i_cfg_valid))
            wdog <= 0;
        else
            wdog <= wdog + 1;
        if (wdog > WDOG_MAX) begin
            $display("simulation failed");
            $finish;
        end
    end

    initial begin
        t_row   rows[$];
        t_row   r;
        t_pixel p;
        t_cal   none;
        none = '0;
        n_errors = 0; n_checked = 0; n_sat = 0; n_div0 = 0; wdog = 0;
        idle_pct_in = 30; idle_pct_out = 30;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_COAD;
        i_cfg_data  = '0;
        cal_coad = 16'd1; cal_exp = '0;
        cal_en_off = 1'b1; cal_en_noise = 1'b1; cal_en_cur = 1'b1; cal_en_prnu = 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: zero count, zero response, extremes
        r.known = 1'b1;
        r.px = '{32'd1000, 8'd0, 32'd5, 32'd5, 32'd1, 32'd1, 18'h10000};
        r.cal = '{ST_DIV0, 48'd0, 48'd0};
        rows.push_back(r);
        r.px = '{32'd1000, 8'd1, 32'd5, 32'd5, 32'd1, 32'd1, 18'd0};
        rows.push_back(r);
        r.px = '{32'd0, 8'd1, 32'd0, 32'd0, 32'd0, 32'd0, 18'h10000};
        r.cal = '{ST_OK, 48'd0, 48'd0};
        rows.push_back(r);
        r.known = 1'b0; r.cal = none;
        r.px = '{32'hFFFF_FFFF, 8'd1, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 18'd1};
        rows.push_back(r);
        r.px = '{32'hFFFF_FFFF, 8'd255, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF, 18'h3FFFF};
        rows.push_back(r);
        r.px = '{32'd12345, 8'd3, 32'hFFFF_0000, 32'd65536, 32'd65536, 32'd65536,
                 18'h10000};
        rows.push_back(r);
        r.px = '{32'd0, 8'd1, 32'h7FFF_FFFF, 32'd0, 32'd0, 32'd0, 18'd1};
        rows.push_back(r);

        idle_pct_in = 0; idle_pct_out = 0;
        foreach (rows[i]) send_pixel(rows[i].px, rows[i].known, rows[i].cal);
        wait_drained();
        set_regs(16'hFFFF, 32'hFFFF_FFFF, 4'b1111);
        foreach (rows[i]) send_pixel(rows[i].px, 1'b0, none);
        wait_drained();
        set_regs(16'd0, 32'd0, 4'b0000);
        send_pixel(rows[5].px, 1'b1, '{ST_DIV0, 48'd0, 48'd0});
        wait_drained();
        set_regs(16'd1, 32'd0, 4'b0000);
        foreach (rows[i]) if (i > 1) send_pixel(rows[i].px, 1'b0, none);

        // random phases, each with fresh register settings
        for (int ph = 0; ph < 12; ph++) begin
            wait_drained();
            case (ph % 4)
                0: set_regs(16'(1 + $urandom_range(3)), $urandom_range(1 << 26), 4'($urandom));
                1: set_regs(16'($urandom), $urandom, 4'($urandom));
                2: set_regs(16'd1, 32'd0, 4'b1111);
                default: set_regs(16'hFFFF, 32'hFFFF_FFFF, 4'($urandom));
            endcase
            idle_pct_in  = (ph == 5) ? 0 : 30;
            idle_pct_out = (ph == 5) ? 0 : 30;
            for (int k = 0; k < N_RANDOM / 12; k++) begin
                p = random_pixel();
                send_pixel(p, 1'b0, none);
                if (k == 40) begin
                    s_axis_tvalid <= 1'b0;
                    while (expected_cal_q.size() != 0) @(posedge i_clk);
                end
            end
        end

        wait_drained();
        $display("checked %0d pixel results (%0d saturated, %0d divide by zero)",
                 n_checked, n_sat, n_div0);
        $display("across %0d register settings, with random stalls on both streams", 16);
        if (n_errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
